// ----- src/rcast_pkg.sv -----
// Shared types, constants and helpers of the grid DDA ray caster.
// Depends on nothing; the top level, the divider and the checker import it.
package rcast_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 10;
  localparam int DIV_NW    = 33;
  localparam int DIV_VW    = 19;
  localparam int DIV_CW    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic signed [37:0] RAY_LIM = 38'sd262144;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PLAYER_X  = 3'd0;
  localparam cfg_idx_t CFG_PLAYER_Y  = 3'd1;
  localparam cfg_idx_t CFG_DIR_X     = 3'd2;
  localparam cfg_idx_t CFG_DIR_Y     = 3'd3;
  localparam cfg_idx_t CFG_PLANE_X   = 3'd4;
  localparam cfg_idx_t CFG_PLANE_Y   = 3'd5;
  localparam cfg_idx_t CFG_GRID_W    = 3'd6;
  localparam cfg_idx_t CFG_GRID_H    = 3'd7;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  localparam logic [1:0] CELL_EMPTY       = 2'd0;
  localparam logic [1:0] CELL_WALL        = 2'd1;
  localparam logic [1:0] CELL_DOOR_CLOSED = 2'd2;
  localparam logic [1:0] CELL_DOOR_OPEN   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_RAYX,
    ST_RAYY,
    ST_DIVX,
    ST_DIVY,
    ST_SIDEX,
    ST_SIDEX_R,
    ST_SIDEY_R,
    ST_STEP,
    ST_CHECK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    return v[32] ? MAX32 : v[31:0];
  endfunction

  function automatic logic signed [19:0] sat_ray(input logic signed [37:0] v);
    if (v > RAY_LIM) return 20'sd262144;
    if (v < -RAY_LIM) return -20'sd262144;
    return v[19:0];
  endfunction

endpackage

// ----- src/rcast_if.sv -----
// Valid/ready channel interfaces of the ray caster: cell/cast items in,
// hit results out. Depends on nothing.
interface rcast_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  cell_col;
  logic [5:0]  cell_row;
  logic [1:0]  cell_kind;
  logic [11:0] screen_column;

  modport source (output valid, func, cell_col, cell_row, cell_kind, screen_column,
                  input ready);
  modport sink   (input valid, func, cell_col, cell_row, cell_kind, screen_column,
                  output ready);
endinterface

interface rcast_out_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  hit_col;
  logic signed [7:0]  hit_row;
  logic               hit_side;
  logic               outside_map;
  logic [31:0]        side_dist_x_out;
  logic [31:0]        side_dist_y_out;
  logic [31:0]        delta_x_out;
  logic [31:0]        delta_y_out;
  logic signed [19:0] ray_x_out;
  logic signed [19:0] ray_y_out;
  logic               step_x_neg;
  logic               step_y_neg;

  modport source (output valid, hit_col, hit_row, hit_side, outside_map,
                  side_dist_x_out, side_dist_y_out, delta_x_out, delta_y_out,
                  ray_x_out, ray_y_out, step_x_neg, step_y_neg, input ready);
  modport sink   (input valid, hit_col, hit_row, hit_side, outside_map,
                  side_dist_x_out, side_dist_y_out, delta_x_out, delta_y_out,
                  ray_x_out, ray_y_out, step_x_neg, step_y_neg, output ready);
endinterface

// ----- src/grid_dda_ray_caster.sv -----
// Top level of the grid DDA ray caster: config registers, control sequencer,
// ray datapath and walk. Depends on rcast_pkg, rcast_if, rcast_div, rcast_map.
//
// Usage:
//  - in_bus carries write beats (func 0: store cell_kind at cell_row/cell_col)
//    and cast beats (func 1: cast the ray of screen_column). out_bus carries
//    one result beat per cast; write beats give no result.
//  - cfg_we/cfg_idx/cfg_data write one register per cycle; write only while
//    the block is idle.
//  - A write beat leaves in_bus.ready high.
//  - A cast beat raises out_bus.valid after a walk of N grid steps, N the
//    number of steps until a wall, a closed door or the edge of the map: the
//    camera term comes from a constant reciprocal multiply at acceptance, then
//    the ray states form the ray, two passes of the shared one-bit-per-cycle
//    divider give the step distances, the side states form the first side
//    distances, each step reads the map, and a finish state loads the result.
//    in_bus.ready is low meanwhile and returns high together with the result beat.
//  - The result sits in an output register; the next beat is taken while it
//    waits. A cast that finishes while an older result is still stalled holds
//    in its last state until out_bus.ready takes the older beat.
//  - Reset (rst_n low, synchronous) returns the sequencer to idle, drops any
//    pending result and loads the register defaults. Map cells keep no reset
//    value: write every cell a ray may reach before casting.
module grid_dda_ray_caster #(
  parameter int MAP_DIM      = 64,
  parameter int SCREEN_WIDTH = 640
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rcast_in_if.sink                      in_bus,
  rcast_out_if.source                   out_bus,
  input  logic                          cfg_we,
  input  rcast_pkg::cfg_idx_t           cfg_idx,
  input  logic [rcast_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcast_pkg::*;

  localparam int AW = $clog2(MAP_DIM*MAP_DIM);

  // camera term floor((2x << FRAC_BITS) / SCREEN_WIDTH) by reciprocal multiply;
  // the dividend has 12 column bits plus the doubling, so CAM_K keeps it exact
  localparam int CAM_K     = 13 + FRAC_BITS + $clog2(SCREEN_WIDTH);
  localparam int CAM_SHIFT = CAM_K - FRAC_BITS - 1;
  localparam logic [30:0] CAM_RECIP =
    31'(((64'd1 << CAM_K) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  // configuration registers
  logic [22:0]        player_x_r, player_y_r;
  logic signed [18:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [6:0]         grid_w_r, grid_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= '0;
      player_y_r <= '0;
      dir_x_r    <= 19'sd65536;
      dir_y_r    <= '0;
      plane_x_r  <= '0;
      plane_y_r  <= 19'sd43690;
      grid_w_r   <= 7'd64;
      grid_h_r   <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PLAYER_X: player_x_r <= cfg_data;
        CFG_PLAYER_Y: player_y_r <= cfg_data;
        CFG_DIR_X:    dir_x_r    <= cfg_data[18:0];
        CFG_DIR_Y:    dir_y_r    <= cfg_data[18:0];
        CFG_PLANE_X:  plane_x_r  <= cfg_data[18:0];
        CFG_PLANE_Y:  plane_y_r  <= cfg_data[18:0];
        CFG_GRID_W:   grid_w_r   <= cfg_data[6:0];
        CFG_GRID_H:   grid_h_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // map bounds, clamped to the store size
  logic [COORD_W-1:0] bound_w, bound_h;
  assign bound_w = (32'(grid_w_r) < MAP_DIM) ? COORD_W'(grid_w_r) : COORD_W'(MAP_DIM);
  assign bound_h = (32'(grid_h_r) < MAP_DIM) ? COORD_W'(grid_h_r) : COORD_W'(MAP_DIM);

  state_t state_r, state_nxt;

  // working registers
  logic signed [30:0]        cam_r;
  logic signed [19:0]        ray_x_r, ray_y_r;
  logic [31:0]               dx_r, dy_r, acc_x_r, acc_y_r;
  logic signed [COORD_W-1:0] col_r, row_r;
  logic                      side_r, outside_r;
  logic signed [52:0]        prod_r;

  // output register
  logic               out_valid_r;
  logic signed [7:0]  o_col_r, o_row_r;
  logic               o_side_r, o_out_r, o_nx_r, o_ny_r;
  logic [31:0]        o_sdx_r, o_sdy_r, o_dx_r, o_dy_r;
  logic signed [19:0] o_rx_r, o_ry_r;

  // shared divider
  div_req_t          div_req;
  logic [DIV_NW-1:0] div_q;
  logic              div_done;

  rcast_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .quot  (div_q),
    .done  (div_done)
  );

  // map store
  logic          map_we;
  logic [AW-1:0] map_waddr, map_raddr;
  logic [1:0]    map_rdata;

  rcast_map #(.MAP_DIM(MAP_DIM)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (in_bus.cell_kind),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  logic in_fire;
  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;

  assign map_we    = in_fire && (in_bus.func == FUNC_WRITE) &&
                     (32'(in_bus.cell_col) < MAP_DIM) && (32'(in_bus.cell_row) < MAP_DIM);
  assign map_waddr = AW'(AW'(in_bus.cell_row) * AW'(MAP_DIM) + AW'(in_bus.cell_col));

  // camera quotient of the offered column, taken with the cast beat
  logic [42:0] cam_prod;
  logic [30:0] cam_q;
  assign cam_prod = 43'(in_bus.screen_column) * 43'(CAM_RECIP);
  assign cam_q    = 31'(cam_prod >> CAM_SHIFT);

  // ray magnitudes and step signs
  logic        nx, ny;
  logic [18:0] mag_x, mag_y;
  assign nx    = ray_x_r < 0;
  assign ny    = ray_y_r < 0;
  assign mag_x = nx ? 19'(-ray_x_r) : 19'(ray_x_r);
  assign mag_y = ny ? 19'(-ray_y_r) : 19'(ray_y_r);

  // first side fractions
  logic [16:0] frac_x, frac_y;
  assign frac_x = nx ? {1'b0, player_x_r[FRAC_BITS-1:0]}
                     : 17'(1 << FRAC_BITS) - {1'b0, player_x_r[FRAC_BITS-1:0]};
  assign frac_y = ny ? {1'b0, player_y_r[FRAC_BITS-1:0]}
                     : 17'(1 << FRAC_BITS) - {1'b0, player_y_r[FRAC_BITS-1:0]};

  // shared multiplier, operands picked by the sequencer state
  logic signed [32:0] mul_a;
  logic signed [19:0] mul_b;
  always_comb begin
    case (state_r)
      ST_RAYX: begin
        mul_a = 33'(cam_r);
        mul_b = 20'(plane_y_r);
      end
      ST_SIDEX: begin
        mul_a = $signed({1'b0, dx_r});
        mul_b = $signed({3'b0, frac_x});
      end
      ST_SIDEX_R: begin
        mul_a = $signed({1'b0, dy_r});
        mul_b = $signed({3'b0, frac_y});
      end
      default: begin
        mul_a = 33'(cam_r);
        mul_b = 20'(plane_x_r);
      end
    endcase
  end

  always_ff @(posedge clk) prod_r <= mul_a * mul_b;

  // floor shift of the plane product plus the view direction
  logic signed [52:0] prod_sh;
  logic signed [37:0] ray_sum_x, ray_sum_y;
  assign prod_sh   = prod_r >>> FRAC_BITS;
  assign ray_sum_x = prod_sh[37:0] + 38'(dir_x_r);
  assign ray_sum_y = prod_sh[37:0] + 38'(dir_y_r);

  logic [31:0] side_sat;
  assign side_sat = sat33(prod_r[48:16]);

  // one DDA step
  logic                      take_x;
  logic [31:0]               acc_x_nxt, acc_y_nxt;
  logic signed [COORD_W-1:0] col_nxt, row_nxt;
  logic                      out_nxt;
  assign take_x    = acc_x_r < acc_y_r;
  assign acc_x_nxt = take_x ? sat33({1'b0, acc_x_r} + {1'b0, dx_r}) : acc_x_r;
  assign acc_y_nxt = take_x ? acc_y_r : sat33({1'b0, acc_y_r} + {1'b0, dy_r});
  assign col_nxt   = take_x ? (nx ? col_r - COORD_W'(1) : col_r + COORD_W'(1)) : col_r;
  assign row_nxt   = take_x ? row_r : (ny ? row_r - COORD_W'(1) : row_r + COORD_W'(1));
  assign out_nxt   = col_nxt[COORD_W-1] || row_nxt[COORD_W-1] ||
                     ($unsigned(col_nxt) >= bound_w) || ($unsigned(row_nxt) >= bound_h);
  // read the cell entered; data comes back in the check state
  assign map_raddr = AW'(AW'($unsigned(row_nxt)) * AW'(MAP_DIM) + AW'($unsigned(col_nxt)));

  logic out_free;
  assign out_free = !out_valid_r || out_bus.ready;

  // sequencer: next state and divider requests
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_NW'(1) << (2*FRAC_BITS);
    div_req.divisor  = mag_x;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_bus.func == FUNC_CAST) state_nxt = ST_MULX;
      end
      ST_MULX:    state_nxt = ST_RAYX;
      ST_RAYX:    state_nxt = ST_RAYY;
      ST_RAYY: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIVX;
      end
      ST_DIVX: begin
        div_req.divisor = mag_y;
        if (div_done) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIVY;
        end
      end
      ST_DIVY:    if (div_done) state_nxt = ST_SIDEX;
      ST_SIDEX:   state_nxt = ST_SIDEX_R;
      ST_SIDEX_R: state_nxt = ST_SIDEY_R;
      ST_SIDEY_R: state_nxt = ST_STEP;
      ST_STEP:    state_nxt = out_nxt ? ST_FIN : ST_CHECK;
      ST_CHECK: begin
        if (map_rdata == CELL_WALL || map_rdata == CELL_DOOR_CLOSED) state_nxt = ST_FIN;
        else state_nxt = ST_STEP;
      end
      ST_FIN:     if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_fire && in_bus.func == FUNC_CAST) cam_r <= $signed(cam_q) - 31'sd65536;
      ST_RAYX: ray_x_r <= sat_ray(ray_sum_x);
      ST_RAYY: begin
        ray_y_r   <= sat_ray(ray_sum_y);
        col_r     <= COORD_W'(player_x_r[22:FRAC_BITS]);
        row_r     <= COORD_W'(player_y_r[22:FRAC_BITS]);
        outside_r <= 1'b0;
        side_r    <= 1'b0;
      end
      ST_DIVX: if (div_done) dx_r <= (mag_x == '0) ? MAX32 : sat33(div_q);
      ST_DIVY: if (div_done) dy_r <= (mag_y == '0) ? MAX32 : sat33(div_q);
      ST_SIDEX_R: acc_x_r <= side_sat;
      ST_SIDEY_R: acc_y_r <= side_sat;
      ST_STEP: begin
        acc_x_r   <= acc_x_nxt;
        acc_y_r   <= acc_y_nxt;
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        side_r    <= !take_x;
        outside_r <= out_nxt;
      end
      default: ;
    endcase
  end

  // result register: load on finish, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      o_col_r  <= col_r[7:0];
      o_row_r  <= row_r[7:0];
      o_side_r <= side_r;
      o_out_r  <= outside_r;
      o_sdx_r  <= acc_x_r;
      o_sdy_r  <= acc_y_r;
      o_dx_r   <= dx_r;
      o_dy_r   <= dy_r;
      o_rx_r   <= ray_x_r;
      o_ry_r   <= ray_y_r;
      o_nx_r   <= nx;
      o_ny_r   <= ny;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.hit_col         = o_col_r;
  assign out_bus.hit_row         = o_row_r;
  assign out_bus.hit_side        = o_side_r;
  assign out_bus.outside_map     = o_out_r;
  assign out_bus.side_dist_x_out = o_sdx_r;
  assign out_bus.side_dist_y_out = o_sdy_r;
  assign out_bus.delta_x_out     = o_dx_r;
  assign out_bus.delta_y_out     = o_dy_r;
  assign out_bus.ray_x_out       = o_rx_r;
  assign out_bus.ray_y_out       = o_ry_r;
  assign out_bus.step_x_neg      = o_nx_r;
  assign out_bus.step_y_neg      = o_ny_r;
endmodule

// ----- src/rcast_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rcast_pkg.
module rcast_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rcast_pkg::div_req_t       req,
  output logic [rcast_pkg::DIV_NW-1:0] quot,
  output logic                      done
);
  import rcast_pkg::*;

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_VW-1:0] div_r;
  logic [DIV_NW-1:0] num_r;
  logic              done_r;
  logic [DIV_VW:0]   trial;
  logic              ge;

  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      div_r <= req.divisor;
      num_r <= req.dividend;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where it fits
      rem_r <= ge ? DIV_VW'(trial - {1'b0, div_r}) : trial[DIV_VW-1:0];
      num_r <= {num_r[DIV_NW-2:0], ge};
    end
  end

  assign quot = num_r;
  assign done = done_r;
endmodule

// ----- src/rcast_map.sv -----
// Map cell store: one write port, one read port with registered data.
// Depends on nothing; depth follows MAP_DIM of the top level.
module rcast_map #(
  parameter int MAP_DIM = 64
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(MAP_DIM*MAP_DIM)-1:0] waddr,
  input  logic [1:0]                         wdata,
  input  logic [$clog2(MAP_DIM*MAP_DIM)-1:0] raddr,
  output logic [1:0]                         rdata
);
  logic [1:0] mem [MAP_DIM*MAP_DIM];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- src/rcast_checker.sv -----
// Port-level checks of the ray caster and their bind to the top level.
// Depends on rcast_pkg and grid_dda_ray_caster.
module rcast_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_func,
  input logic out_valid,
  input logic out_ready
);
  import rcast_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_CAST |=> !in_ready)
    else $error("input taken during a cast");

  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_WRITE |=> in_ready)
    else $error("write beat stalled the input");

  a_rose_after_cast: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a cast in progress");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind grid_dda_ray_caster rcast_checker u_rcast_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_func   (in_bus.func),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready)
);
